>>> rtl/ltpg_pkg.sv
// shared types, constants and register codes for the load and thermal p-state governor
`timescale 1ns / 1ps

package ltpg_pkg;

	localparam int unsigned TickW     = 64;
	localparam int unsigned HalfW     = TickW / 2;
	localparam int unsigned ThrW      = 11;
	localparam int unsigned ProdW     = TickW + ThrW;
	localparam int unsigned PartW     = HalfW + ThrW;
	localparam int unsigned LoadShift = 10;
	localparam int unsigned TempW     = 7;
	localparam int unsigned RunW      = 8;
	localparam int unsigned PsW       = 3;
	localparam int unsigned CapW      = 2;
	localparam int unsigned NumThr    = 3;

	localparam int unsigned MidDepth  = 4;
	localparam int unsigned MidPtrW   = 2;
	localparam int unsigned MidCntW   = 3;
	localparam int unsigned OutDepth  = 2;
	localparam int unsigned OutCntW   = 2;

	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 11;

	localparam logic [PsW-1:0] P_FAST   = 3'd0;
	localparam logic [PsW-1:0] P_MIDDLE = 3'd2;
	localparam logic [PsW-1:0] P_SLOW   = 3'd5;
	localparam logic [PsW-1:0] P_IDLE   = 3'd7;

	localparam logic [CapW-1:0] CAP_NONE = 2'd0;
	localparam logic [CapW-1:0] CAP_HOT  = 2'd1;
	localparam logic [CapW-1:0] CAP_CRIT = 2'd2;

	localparam logic [RunW-1:0] RUN_MAX = 8'd255;

	localparam logic [ThrW-1:0]  RST_HIGH_THR = 11'd410;
	localparam logic [ThrW-1:0]  RST_MID_THR  = 11'd205;
	localparam logic [ThrW-1:0]  RST_LOW_THR  = 11'd82;
	localparam logic [RunW-1:0]  RST_DOWN     = 8'd6;
	localparam logic [TempW-1:0] RST_HOT      = 7'd85;
	localparam logic [TempW-1:0] RST_RECOVERY = 7'd75;
	localparam logic [TempW-1:0] RST_CRIT     = 7'd90;

	typedef enum logic [CfgIdxW-1:0] {
		REG_HIGH_THR = 3'd0,
		REG_MID_THR  = 3'd1,
		REG_LOW_THR  = 3'd2,
		REG_DOWN     = 3'd3,
		REG_HOT      = 3'd4,
		REG_RECOVERY = 3'd5,
		REG_CRIT     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [ThrW-1:0]  high_threshold;
		logic [ThrW-1:0]  mid_threshold;
		logic [ThrW-1:0]  low_threshold;
		logic [RunW-1:0]  down_samples;
		logic [TempW-1:0] hot_celsius;
		logic [TempW-1:0] recovery_celsius;
		logic [TempW-1:0] critical_celsius;
	} cfg_t;

	typedef struct packed {
		logic [TickW-1:0] busy_ticks;
		logic [TickW-1:0] total_ticks;
		logic             temp_valid;
		logic [TempW-1:0] temp_celsius;
	} sample_t;

	typedef struct packed {
		logic [PsW-1:0]  pstate_now;
		logic            pstate_write;
		logic            boost_active;
		logic [CapW-1:0] thermal_cap;
		logic [CapW-1:0] fastest_allowed;
		logic [PsW-1:0]  demand_state;
		logic [PsW-1:0]  raw_demand_state;
		logic [RunW-1:0] slow_run;
	} result_t;

	typedef struct packed {
		logic             prime;
		logic [PsW-1:0]   raw;
		logic             temp_valid;
		logic [TempW-1:0] temp_celsius;
	} mid_item_t;

endpackage

>>> rtl/ltpg_front.sv
// front end: counter deltas, threshold products and raw demand classification
`timescale 1ns / 1ps

module ltpg_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  ltpg_pkg::sample_t         sample,
	input  ltpg_pkg::cfg_t            cfg,
	output logic                      mid_push,
	output ltpg_pkg::mid_item_t       mid_item,
	output logic [1:0]                inflight
);

	localparam int unsigned TickW  = ltpg_pkg::TickW;
	localparam int unsigned HalfW  = ltpg_pkg::HalfW;
	localparam int unsigned ThrW   = ltpg_pkg::ThrW;
	localparam int unsigned ProdW  = ltpg_pkg::ProdW;
	localparam int unsigned PartW  = ltpg_pkg::PartW;
	localparam int unsigned TempW  = ltpg_pkg::TempW;
	localparam int unsigned NumThr = ltpg_pkg::NumThr;

	logic [TickW-1:0] prev_busy_q, prev_total_q;
	logic             primed_q;

	logic             v_s1, prime_s1, grew_s1, tv_s1;
	logic [TickW-1:0] db_s1, dt_s1;
	logic [TempW-1:0] temp_s1;

	logic             v_s2, prime_s2, grew_s2, tv_s2;
	logic [ProdW-1:0] lhs_s2;
	logic [PartW-1:0] plo_s2 [NumThr];
	logic [PartW-1:0] phi_s2 [NumThr];
	logic [TempW-1:0] temp_s2;

	logic [ThrW-1:0]  thr [NumThr];
	logic [ProdW-1:0] rhs [NumThr];
	logic [NumThr-1:0] meet;

	assign thr[0] = cfg.high_threshold;
	assign thr[1] = cfg.mid_threshold;
	assign thr[2] = cfg.low_threshold;

	// counter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q     <= 1'b0;
			prev_busy_q  <= '0;
			prev_total_q <= '0;
		end else if (accept) begin
			primed_q     <= 1'b1;
			prev_busy_q  <= sample.busy_ticks;
			prev_total_q <= sample.total_ticks;
		end
	end

	// stage 1: deltas
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prime_s1 <= !primed_q;
			grew_s1  <= sample.total_ticks > prev_total_q;
			db_s1    <= sample.busy_ticks - prev_busy_q;
			dt_s1    <= sample.total_ticks - prev_total_q;
			tv_s1    <= sample.temp_valid;
			temp_s1  <= sample.temp_celsius;
		end
	end

	// stage 2: partial products of total delta and thresholds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prime_s2 <= prime_s1;
			grew_s2  <= grew_s1;
			lhs_s2   <= {1'b0, db_s1, {ltpg_pkg::LoadShift{1'b0}}};
			tv_s2    <= tv_s1;
			temp_s2  <= temp_s1;
			for (int i = 0; i < NumThr; i++) begin
				plo_s2[i] <= PartW'(dt_s1[HalfW-1:0]) * PartW'(thr[i]);
				phi_s2[i] <= PartW'(dt_s1[TickW-1:HalfW]) * PartW'(thr[i]);
			end
		end
	end

	// combine and compare
	always_comb begin
		for (int i = 0; i < NumThr; i++) begin
			rhs[i]  = ProdW'(plo_s2[i]) + (ProdW'(phi_s2[i]) << HalfW);
			meet[i] = grew_s2 ? (lhs_s2 >= rhs[i]) : (thr[i] == '0);
		end
	end

	always_comb begin
		mid_item.prime        = prime_s2;
		mid_item.temp_valid   = tv_s2;
		mid_item.temp_celsius = temp_s2;
		priority if (prime_s2) begin
			mid_item.raw = ltpg_pkg::P_FAST;
		end else if (meet[0]) begin
			mid_item.raw = ltpg_pkg::P_FAST;
		end else if (meet[1]) begin
			mid_item.raw = ltpg_pkg::P_MIDDLE;
		end else if (meet[2]) begin
			mid_item.raw = ltpg_pkg::P_SLOW;
		end else begin
			mid_item.raw = ltpg_pkg::P_IDLE;
		end
	end

	assign mid_push = v_s2;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};

endmodule

>>> rtl/ltpg_mid_queue.sv
// short queue between classification front end and state update back end
`timescale 1ns / 1ps

module ltpg_mid_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  ltpg_pkg::mid_item_t                 push_item,
	input  logic                                pop,
	output ltpg_pkg::mid_item_t                 head,
	output logic                                empty,
	output logic [ltpg_pkg::MidCntW-1:0]        count
);

	localparam int unsigned MidPtrW = ltpg_pkg::MidPtrW;
	localparam int unsigned MidCntW = ltpg_pkg::MidCntW;

	ltpg_pkg::mid_item_t    mem_q [ltpg_pkg::MidDepth];
	logic [MidPtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [MidCntW-1:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + MidCntW'(push) - MidCntW'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MidCntW'(ltpg_pkg::MidDepth))
		else $error("mid queue count beyond depth");
`endif

endmodule

>>> rtl/ltpg_back.sv
// back end: thermal cap, ramp policy, boost flag and result buffer
`timescale 1ns / 1ps

module ltpg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltpg_pkg::cfg_t       cfg,
	input  logic                 mid_empty,
	input  ltpg_pkg::mid_item_t  mid_head,
	output logic                 mid_pop,
	input  logic                 pop,
	output logic                 empty,
	output ltpg_pkg::result_t    result
);

	localparam int unsigned PsW     = ltpg_pkg::PsW;
	localparam int unsigned CapW    = ltpg_pkg::CapW;
	localparam int unsigned RunW    = ltpg_pkg::RunW;
	localparam int unsigned OutCntW = ltpg_pkg::OutCntW;

	logic [PsW-1:0]  cur_q;
	logic [RunW-1:0] run_q;
	logic [CapW-1:0] lvl_q;
	logic            boost_q;

	ltpg_pkg::result_t obuf_q [ltpg_pkg::OutDepth];
	logic              owr_q, ord_q;
	logic [OutCntW-1:0] ocnt_q;

	logic              out_pop;
	logic [CapW-1:0]   lvl_n;
	logic [PsW-1:0]    demand, tgt;
	logic [RunW-1:0]   run_inc, run_n;
	logic              boost_n;
	ltpg_pkg::result_t res;

	assign out_pop = pop && (ocnt_q != '0);
	assign mid_pop = !mid_empty && ((ocnt_q != OutCntW'(ltpg_pkg::OutDepth)) || out_pop);

	always_comb begin
		lvl_n = lvl_q;
		if (mid_head.temp_valid) begin
			priority if (mid_head.temp_celsius >= cfg.critical_celsius) begin
				lvl_n = ltpg_pkg::CAP_CRIT;
			end else if (mid_head.temp_celsius >= cfg.hot_celsius) begin
				lvl_n = ltpg_pkg::CAP_HOT;
			end else if (mid_head.temp_celsius < cfg.recovery_celsius) begin
				lvl_n = ltpg_pkg::CAP_NONE;
			end
		end

		demand  = (mid_head.raw < {1'b0, lvl_n}) ? {1'b0, lvl_n} : mid_head.raw;
		run_inc = (run_q == ltpg_pkg::RUN_MAX) ? run_q : run_q + 1'b1;

		priority if (demand < cur_q) begin
			tgt   = demand;
			run_n = '0;
		end else if (demand > cur_q) begin
			if (run_inc >= cfg.down_samples) begin
				tgt   = ((cur_q + 1'b1) > demand) ? demand : cur_q + 1'b1;
				run_n = '0;
			end else begin
				tgt   = cur_q;
				run_n = run_inc;
			end
		end else begin
			tgt   = cur_q;
			run_n = '0;
		end

		boost_n = (demand == ltpg_pkg::P_FAST) && (lvl_n == ltpg_pkg::CAP_NONE);

		if (mid_head.prime) begin
			res.pstate_now       = cur_q;
			res.pstate_write     = 1'b0;
			res.boost_active     = boost_q;
			res.thermal_cap      = lvl_q;
			res.fastest_allowed  = lvl_q;
			res.demand_state     = ltpg_pkg::P_FAST;
			res.raw_demand_state = ltpg_pkg::P_FAST;
			res.slow_run         = run_q;
		end else begin
			res.pstate_now       = tgt;
			res.pstate_write     = (tgt != cur_q);
			res.boost_active     = boost_n;
			res.thermal_cap      = lvl_n;
			res.fastest_allowed  = lvl_n;
			res.demand_state     = demand;
			res.raw_demand_state = mid_head.raw;
			res.slow_run         = run_n;
		end
	end

	// governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= ltpg_pkg::P_FAST;
			run_q   <= '0;
			lvl_q   <= ltpg_pkg::CAP_NONE;
			boost_q <= 1'b0;
		end else if (mid_pop && !mid_head.prime) begin
			cur_q   <= tgt;
			run_q   <= run_n;
			lvl_q   <= lvl_n;
			boost_q <= boost_n;
		end
	end

	// result buffer
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			obuf_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (mid_pop) begin
				owr_q <= !owr_q;
			end
			if (out_pop) begin
				ord_q <= !ord_q;
			end
			ocnt_q <= ocnt_q + OutCntW'(mid_pop) - OutCntW'(out_pop);
		end
	end

	assign empty  = (ocnt_q == '0);
	assign result = obuf_q[ord_q];

`ifndef SYNTH
	a_write_matches_change: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |=> ((cur_q != $past(cur_q)) == $past(res.pstate_write)))
		else $error("p-state change disagrees with write flag");

	a_demand_obeys_cap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.demand_state >= {1'b0, result.fastest_allowed}))
		else $error("demand faster than thermal cap allows");

	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OutCntW'(ltpg_pkg::OutDepth))
		else $error("result buffer count beyond depth");
`endif

endmodule

>>> rtl/load_thermal_pstate_governor.sv
// top level of the load and thermal p-state governor with configuration registers
`timescale 1ns / 1ps

// Takes one sample per clock while full is low: the front end computes counter
// deltas, multiplies the total delta by the three load thresholds (split into
// 32-bit halves) and classifies the load, and the back end applies the thermal
// cap, ramp policy and boost flag as it pops each item from the mid queue. A
// sample passes through the two front stages, the mid queue and the result
// buffer before pop can take it; full rises only when the four-entry queue
// between the two halves plus the two front stages in flight would overflow,
// and the two-entry result buffer lets pop stall freely.
// The first sample after reset only primes the counters. Registers are to be
// written while no sample is in flight; cfg_ready is always high.

module load_thermal_pstate_governor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  ltpg_pkg::sample_t               sample,
	output logic                            empty,
	input  logic                            pop,
	output ltpg_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ltpg_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [ltpg_pkg::CfgDataW-1:0]   cfg_data
);

	localparam int unsigned MidCntW = ltpg_pkg::MidCntW;

	ltpg_pkg::cfg_t       cfg_q;
	logic                 accept;
	logic                 mid_push, mid_pop, mid_empty;
	ltpg_pkg::mid_item_t  mid_item, mid_head;
	logic [1:0]           inflight;
	logic [MidCntW-1:0]   mid_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_threshold   <= ltpg_pkg::RST_HIGH_THR;
			cfg_q.mid_threshold    <= ltpg_pkg::RST_MID_THR;
			cfg_q.low_threshold    <= ltpg_pkg::RST_LOW_THR;
			cfg_q.down_samples     <= ltpg_pkg::RST_DOWN;
			cfg_q.hot_celsius      <= ltpg_pkg::RST_HOT;
			cfg_q.recovery_celsius <= ltpg_pkg::RST_RECOVERY;
			cfg_q.critical_celsius <= ltpg_pkg::RST_CRIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ltpg_pkg::REG_HIGH_THR: begin
					cfg_q.high_threshold <= cfg_data;
				end
				ltpg_pkg::REG_MID_THR: begin
					cfg_q.mid_threshold <= cfg_data;
				end
				ltpg_pkg::REG_LOW_THR: begin
					cfg_q.low_threshold <= cfg_data;
				end
				ltpg_pkg::REG_DOWN: begin
					cfg_q.down_samples <= cfg_data[ltpg_pkg::RunW-1:0];
				end
				ltpg_pkg::REG_HOT: begin
					cfg_q.hot_celsius <= cfg_data[ltpg_pkg::TempW-1:0];
				end
				ltpg_pkg::REG_RECOVERY: begin
					cfg_q.recovery_celsius <= cfg_data[ltpg_pkg::TempW-1:0];
				end
				ltpg_pkg::REG_CRIT: begin
					cfg_q.critical_celsius <= cfg_data[ltpg_pkg::TempW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// credit: every sample in flight must find room in the mid queue
	assign full   = (mid_count + MidCntW'(inflight)) >= MidCntW'(ltpg_pkg::MidDepth);
	assign accept = push && !full;

	ltpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (sample),
		.cfg      (cfg_q),
		.mid_push (mid_push),
		.mid_item (mid_item),
		.inflight (inflight)
	);

	ltpg_mid_queue u_mid_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mid_push),
		.push_item (mid_item),
		.pop       (mid_pop),
		.head      (mid_head),
		.empty     (mid_empty),
		.count     (mid_count)
	);

	ltpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef SYNTH
	a_no_mid_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_push && !mid_pop) |-> (mid_count != MidCntW'(ltpg_pkg::MidDepth)))
		else $error("transfer into full mid queue");
`endif

endmodule
